@@ hdl/gpioc_pkg.sv @@
// Shared types and constants for the GPIO controller with interrupts.
// Holds the register map, operation codes and the word layouts.
// No dependencies.
package gpioc_pkg;

  localparam int DATA_W        = 32;
  localparam int NUM_LINES_DEF = 32;
  localparam int ADDR_W        = 6;
  localparam int OP_W          = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ   = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd2;

  // Register word addresses (byte offset / 4)
  localparam logic [ADDR_W-1:0] A_DOUT  = 6'd0;
  localparam logic [ADDR_W-1:0] A_DIN   = 6'd1;
  localparam logic [ADDR_W-1:0] A_DIR   = 6'd2;
  localparam logic [ADDR_W-1:0] A_IEN   = 6'd8;
  localparam logic [ADDR_W-1:0] A_RAW   = 6'd9;
  localparam logic [ADDR_W-1:0] A_MASK  = 6'd11;
  localparam logic [ADDR_W-1:0] A_CLR   = 6'd12;
  localparam logic [ADDR_W-1:0] A_TYPE  = 6'd13;
  localparam logic [ADDR_W-1:0] A_BOTH  = 6'd14;
  localparam logic [ADDR_W-1:0] A_POL   = 6'd15;
  localparam logic [ADDR_W-1:0] A_DEBEN = 6'd16;
  localparam logic [ADDR_W-1:0] A_DEBPS = 6'd17;

  // Input word, first field in the highest bits
  typedef struct packed {
    logic [DATA_W-1:0] pin_in;
    logic [DATA_W-1:0] write_data;
    logic [ADDR_W-1:0] reg_addr;
    logic [OP_W-1:0]   op;
  } item_t;

  // Result word, first field in the highest bits
  typedef struct packed {
    logic              irq;
    logic [DATA_W-1:0] pin_drive;
    logic [DATA_W-1:0] pin_out;
    logic [DATA_W-1:0] read_data;
  } result_t;

  localparam int ITEM_W   = $bits(item_t);
  localparam int RESULT_W = $bits(result_t);
  localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

@@ hdl/gpioc_in_reg.sv @@
// Input register stage of the GPIO controller.
// Depends on gpioc_pkg for the input word layout.
module gpioc_in_reg
  import gpioc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  input  item_t s_item,
  input  logic  advance,
  output logic  valid,
  output item_t item
);

  // Take a new word whenever the held one is empty or leaves this cycle.
  assign s_tready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= s_item;
    end
  end

endmodule

@@ hdl/gpioc_core.sv @@
// Register file, pin event detection and read mux of the GPIO controller.
// Depends on gpioc_pkg for the register map and word layouts.
module gpioc_core
  import gpioc_pkg::*;
#(
  parameter int NUM_LINES = NUM_LINES_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  output result_t res
);

  localparam int LW = NUM_LINES;

  logic [LW-1:0]     out_data, dir_bits, irq_enable, raw_status, irq_mask;
  logic [LW-1:0]     edge_select, both_edges, polarity, prev_pins, debounce_enable;
  logic [DATA_W-1:0] debounce_prescale;

  logic [LW-1:0]     out_data_next, dir_bits_next, irq_enable_next, irq_mask_next;
  logic [LW-1:0]     edge_select_next, both_edges_next, polarity_next;
  logic [LW-1:0]     debounce_enable_next, raw_status_next;
  logic [DATA_W-1:0] debounce_prescale_next;

  logic [LW-1:0]     pins, wd, rise, fall, edge_ev, level_ev, events, clr;
  logic [DATA_W-1:0] rd;
  logic              is_write;

  assign pins = item.pin_in[LW-1:0];
  assign wd   = item.write_data[LW-1:0];

  // Events judge against the previous sample and the held settings.
  assign rise     = pins & ~prev_pins;
  assign fall     = ~pins & prev_pins;
  assign edge_ev  = (both_edges & (rise | fall)) |
                    (~both_edges & ((polarity & rise) | (~polarity & fall)));
  assign level_ev = (polarity & pins) | (~polarity & ~pins);
  assign events   = irq_enable & ((edge_select & edge_ev) | (~edge_select & level_ev));

  always_comb begin
    rd = '0;
    if (item.op == OP_READ) begin
      unique case (item.reg_addr)
        A_DOUT:  rd = DATA_W'(out_data);
        A_DIN:   rd = DATA_W'(pins);
        A_DIR:   rd = DATA_W'(dir_bits);
        A_IEN:   rd = DATA_W'(irq_enable);
        A_RAW:   rd = DATA_W'(raw_status);
        A_MASK:  rd = DATA_W'(irq_mask);
        A_TYPE:  rd = DATA_W'(edge_select);
        A_BOTH:  rd = DATA_W'(both_edges);
        A_POL:   rd = DATA_W'(polarity);
        A_DEBEN: rd = DATA_W'(debounce_enable);
        A_DEBPS: rd = debounce_prescale;
        default: rd = '0;
      endcase
    end
  end

  assign is_write = (item.op == OP_WRITE);

  always_comb begin
    out_data_next          = out_data;
    dir_bits_next          = dir_bits;
    irq_enable_next        = irq_enable;
    irq_mask_next          = irq_mask;
    edge_select_next       = edge_select;
    both_edges_next        = both_edges;
    polarity_next          = polarity;
    debounce_enable_next   = debounce_enable;
    debounce_prescale_next = debounce_prescale;
    clr                    = '0;
    if (is_write) begin
      unique case (item.reg_addr)
        A_DOUT:  out_data_next          = wd;
        A_DIR:   dir_bits_next          = wd;
        A_IEN:   irq_enable_next        = wd;
        A_MASK:  irq_mask_next          = wd;
        A_CLR:   clr                    = wd;
        A_TYPE:  edge_select_next       = wd;
        A_BOTH:  both_edges_next        = wd;
        A_POL:   polarity_next          = wd;
        A_DEBEN: debounce_enable_next   = wd;
        A_DEBPS: debounce_prescale_next = item.write_data;
        default: clr                    = '0;
      endcase
    end
    // A new event wins over a clear of the same bit.
    raw_status_next = (raw_status & ~clr) | events;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_data          <= '0;
      dir_bits          <= '0;
      irq_enable        <= '0;
      raw_status        <= '0;
      irq_mask          <= '0;
      edge_select       <= '0;
      both_edges        <= '0;
      polarity          <= '0;
      prev_pins         <= '0;
      debounce_enable   <= '0;
      debounce_prescale <= '0;
    end else if (fire) begin
      out_data          <= out_data_next;
      dir_bits          <= dir_bits_next;
      irq_enable        <= irq_enable_next;
      raw_status        <= raw_status_next;
      irq_mask          <= irq_mask_next;
      edge_select       <= edge_select_next;
      both_edges        <= both_edges_next;
      polarity          <= polarity_next;
      prev_pins         <= pins;
      debounce_enable   <= debounce_enable_next;
      debounce_prescale <= debounce_prescale_next;
    end
  end

  assign res.read_data = rd;
  assign res.pin_out   = DATA_W'(out_data_next);
  assign res.pin_drive = DATA_W'(dir_bits_next);
  assign res.irq       = |(raw_status_next & ~irq_mask_next);

endmodule

@@ hdl/gpioc_out_reg.sv @@
// Result register of the GPIO controller; holds a word until it is taken.
// Depends on gpioc_pkg for the result word layout.
module gpioc_out_reg
  import gpioc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res_in,
  input  logic    m_tready,
  output logic    m_tvalid,
  output logic    room,
  output result_t res
);

  // Free when empty or when the held word leaves this cycle.
  assign room = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (room) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_in;
    end
  end

endmodule

@@ hdl/gpio_controller_with_interrupts.sv @@
// GPIO controller with edge and level interrupts: a 32-line register block
// behind a streaming port, one input word in and one result word out per item.
// Each input word samples the pins and may read or write one register (output
// data, live pins, direction, interrupt enable, raw status, mask, clear, type,
// polarity, both-edges, debounce enable and prescale; debounce is stored only).
// An item passes an input register, then shallow per-bit logic that updates
// the register file and forms the result, then a result register. One item
// is accepted every cycle as long as the result side keeps taking words; the
// result register's hold under m_tready low is what stalls the input side.
// Pin events are judged against the pin sample of the previous item, not the
// previous clock, so idle cycles do not count as samples. The irq bit in each
// result is the OR of raw status bits whose mask bit is 0, after that item.
// Depends on gpioc_pkg, gpioc_in_reg, gpioc_core and gpioc_out_reg.
module gpio_controller_with_interrupts
  import gpioc_pkg::*;
#(
  parameter int NUM_LINES = NUM_LINES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // op[1:0], reg_addr[7:2], write_data[39:8], pin_in[71:40]
  input  logic [ITEM_W-1:0]      s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // read_data[31:0], pin_out[63:32], pin_drive[95:64], irq[96], zero fill above
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  logic    in_valid;
  item_t   item;
  logic    room;
  logic    fire;
  result_t res_comb;
  result_t res_held;

  // Advance the held word into the result register when that has room.
  assign fire = in_valid && room;

  gpioc_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_item   (item_t'(s_tdata)),
    .advance  (fire),
    .valid    (in_valid),
    .item     (item)
  );

  gpioc_core #(
    .NUM_LINES (NUM_LINES)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (item),
    .res  (res_comb)
  );

  gpioc_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (fire),
    .res_in   (res_comb),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .room     (room),
    .res      (res_held)
  );

  assign m_tdata = OUT_TDATA_W'(res_held);

`ifndef NO_ASSERTIONS
  // A word that advances must show up at the result side next cycle.
  a_fire_shows: assert property (@(posedge clk) disable iff (rst)
    fire |=> m_tvalid)
    else $error("advanced word did not reach the result register");

  // Nothing advances over a stalled result.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !fire)
    else $error("result overwritten while stalled");

  // Only reads return data.
  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    (fire && item.op != OP_READ) |-> (res_comb.read_data == '0))
    else $error("non-read returned nonzero read data");
`endif

endmodule
